FILE: sv/sample_autocorrelation_unit_macros.svh
// assertion macros for the sample autocorrelation unit
// used by the top level only, needs a clock named clock and a reset named reset
`ifndef SAMPLE_AUTOCORRELATION_UNIT_MACROS_SVH
`define SAMPLE_AUTOCORRELATION_UNIT_MACROS_SVH

// same-cycle implication
`define SAC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sample autocorrelation check failed");

// next-cycle implication
`define SAC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sample autocorrelation check failed");

`endif

FILE: sv/sac_pkg.sv
// shared types and constants of the sample autocorrelation unit
// no dependencies
`timescale 1ns / 1ps
package sac_pkg;
   localparam int LAGS      = 64;
   localparam int LAG_BITS  = 6;
   localparam int CORR_BITS = 16;
   localparam int Q_BITS    = 15;
   localparam logic [Q_BITS-1:0] Q_ONE = 15'd16384;
   localparam logic [LAG_BITS-1:0] MAX_LAG_RESET = 6'd40;

   typedef struct packed {
      logic clear;
      logic shift;
      logic dvalid;
   } cell_ctrl_type;

   typedef enum logic [4:0] {
      S_LOAD  = 5'b00001,
      S_CALC  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_DIV   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;
endpackage

FILE: sv/sac_cell.sv
// one lag cell: tap delay, product register and lag accumulator
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_cell #(
   parameter int DW = 28,
   parameter int AW = 67
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sac_pkg::cell_ctrl_type ctrl,
   input  logic signed [DW-1:0]   d_cur,
   input  logic signed [DW-1:0]   tap_in,
   input  logic                   tap_vin,
   output logic signed [DW-1:0]   tap_out,
   output logic                   tap_vout,
   input  logic signed [AW-1:0]   acc_in,
   output logic signed [AW-1:0]   acc_out
);
   import sac_pkg::*;

   logic signed [DW-1:0]   tap_ff;
   logic                   tapv_ff;
   logic signed [2*DW-1:0] prod_ff;
   logic                   pv_ff;
   logic signed [AW-1:0]   acc_ff, acc_in_w;

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      prod_ff <= d_cur * tap_in;
   end

   always_comb begin
      acc_in_w = acc_ff;
      if (ctrl.clear) acc_in_w = '0;
      else if (ctrl.shift) acc_in_w = acc_in;
      else if (pv_ff) acc_in_w = acc_ff + AW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tapv_ff <= 1'b0;
         pv_ff   <= 1'b0;
         acc_ff  <= '0;
      end else begin
         tapv_ff <= tap_vin & ~ctrl.clear;
         pv_ff   <= ctrl.dvalid & tap_vin & ~ctrl.clear;
         acc_ff  <= acc_in_w;
      end
   end

   assign tap_out  = tap_ff;
   assign tap_vout = tapv_ff;
   assign acc_out  = acc_ff;
endmodule

FILE: sv/sac_div.sv
// restoring divider, one quotient bit per cycle, gives trunc(num*2^14/den)
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_div #(
   parameter int AW = 67
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [AW-1:0]              num,
   input  logic signed [AW-1:0]              den,
   output logic                              done,
   output logic signed [sac_pkg::CORR_BITS-1:0] quo
);
   import sac_pkg::*;

   logic [AW:0]       r_ff, t_w, d_w;
   logic [Q_BITS-1:0] q_ff, q_c;
   logic [3:0]        step_ff;
   logic              busy_ff, neg_ff, done_ff;
   logic [AW-1:0]     mag_w;
   logic              ge_w;

   assign mag_w = num[AW-1] ? AW'(-num) : AW'(num);
   assign d_w   = {1'b0, den};
   assign t_w   = (step_ff == 4'd0) ? r_ff : {r_ff[AW-1:0], 1'b0};
   assign ge_w  = t_w >= d_w;

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff   <= {1'b0, mag_w};
         q_ff   <= '0;
         neg_ff <= num[AW-1];
      end else if (busy_ff) begin
         r_ff <= ge_w ? t_w - d_w : t_w;
         q_ff <= {q_ff[Q_BITS-2:0], ge_w};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && step_ff == 4'(Q_BITS - 1);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'(Q_BITS - 1)) busy_ff <= 1'b0;
         end
      end
   end

   // clamp to 1.0 and restore sign
   assign q_c  = (q_ff > Q_ONE) ? Q_ONE : q_ff;
   assign quo  = neg_ff ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
   assign done = done_ff;
endmodule

FILE: sv/sample_autocorrelation_unit.sv
// channel   dir  fields (tdata low bit up)            transfer
// req_      in   sample[15:0]; tlast = last             tvalid & tready
// rsp_      out  lag[5:0], correlation[21:6]; tuser =    tvalid & tready
//                zero_variance; tlast = last_result
// csr_      in   max_lag[5:0]                           csr_we
// one sample is loaded per cycle in the load state; after the last one the deviations stream through
// a row of 64 lag cells, then each of the max_lag+1 values passes through the
// shared bit-serial divider and then the output handshake.
// reset is synchronous; the sample store needs no clearing.
// a stalled result holds the divider and the cell row.
// depends on sac_pkg, sac_cell, sac_div and the macro header
`timescale 1ns / 1ps
`include "sample_autocorrelation_unit_macros.svh"
module sample_autocorrelation_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample[15:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // lag[5:0], correlation[21:6], zeros
   output logic        rsp_tuser,   // zero_variance
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata    // max_lag[5:0]
);
   import sac_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int IW = $clog2(MAX_SAMPLES);
   localparam int SW = SAMPLE_BITS + CW;
   localparam int DW = SW + 1;
   localparam int AW = 2 * DW + CW;

   state_type state_ff, state_in;
   logic [LAG_BITS-1:0]    max_lag_ff, lag_ff;
   logic [CW-1:0]          cnt_ff, rd_ff;
   logic [SW-1:0]          sum_ff;
   logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] rd_data_ff, x_w;
   logic                   rd_v_ff, dv_ff, pv_ff, start_ff;
   logic signed [DW-1:0]   dev_ff;
   logic signed [AW-1:0]   den_ff;
   logic [SW-1:0]          nx_w;
   logic                   req_xfer, rsp_xfer, issue_w, div_done;
   logic signed [CORR_BITS-1:0] quo_w, corr_ff;
   logic                   rsp_v_ff;
   cell_ctrl_type          ctrl;

   logic signed [DW-1:0] tap   [LAGS+1];
   logic                 tapv  [LAGS+1];
   logic signed [AW-1:0] acc_l [LAGS+1];

   assign x_w      = SAMPLE_BITS'(req_tdata);
   assign req_tready = state_ff == S_LOAD;
   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_v_ff & rsp_tready;
   assign issue_w  = state_ff == S_CALC;

   always_ff @(posedge clock) begin
      if (req_xfer && cnt_ff < CW'(MAX_SAMPLES)) mem[cnt_ff[IW-1:0]] <= x_w;
      if (issue_w) rd_data_ff <= mem[rd_ff[IW-1:0]];
   end

   // deviation n*x - S
   assign nx_w = SW'(cnt_ff * rd_data_ff);
   always_ff @(posedge clock) begin
      dev_ff <= $signed({1'b0, nx_w}) - $signed({1'b0, sum_ff});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:  if (req_xfer && req_tlast) state_in = S_CALC;
         S_CALC:  if (rd_ff + CW'(1) == cnt_ff) state_in = S_DRAIN;
         S_DRAIN: if (!rd_v_ff && !dv_ff && !pv_ff) state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_EMIT;
         S_EMIT:  if (rsp_xfer) state_in = (lag_ff == max_lag_ff) ? S_LOAD : S_DIV;
         default: state_in = S_LOAD;
      endcase
   end

   assign ctrl.clear  = req_xfer & req_tlast;
   assign ctrl.shift  = rsp_xfer;
   assign ctrl.dvalid = dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         max_lag_ff <= MAX_LAG_RESET;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         rd_ff      <= '0;
         lag_ff     <= '0;
         rd_v_ff    <= 1'b0;
         dv_ff      <= 1'b0;
         pv_ff      <= 1'b0;
         start_ff   <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) max_lag_ff <= csr_wdata;
         rd_v_ff  <= issue_w;
         dv_ff    <= rd_v_ff;
         pv_ff    <= dv_ff;
         // first lag after the drain, next lag after each result transfer
         start_ff <= (state_ff == S_DRAIN && state_in == S_DIV) ||
                     (rsp_xfer && lag_ff != max_lag_ff);
         if (req_xfer && cnt_ff < CW'(MAX_SAMPLES)) begin
            cnt_ff <= cnt_ff + CW'(1);
            sum_ff <= sum_ff + SW'(x_w);
         end
         if (ctrl.clear) rd_ff <= '0;
         else if (issue_w) rd_ff <= rd_ff + CW'(1);
         if (state_ff == S_DRAIN && state_in == S_DIV) begin
            lag_ff   <= '0;
         end
         if (div_done) rsp_v_ff <= 1'b1;
         if (rsp_xfer) begin
            rsp_v_ff <= 1'b0;
            if (lag_ff == max_lag_ff) begin
               cnt_ff <= '0;
               sum_ff <= '0;
            end else begin
               lag_ff   <= lag_ff + LAG_BITS'(1);
            end
         end
      end
   end

   // lag 0 accumulator is the centered sum of squares
   always_ff @(posedge clock) begin
      if (state_ff == S_DRAIN) den_ff <= acc_l[0];
      if (div_done) corr_ff <= (den_ff == '0) ? '0 : quo_w;
   end

   assign tap[0]      = dev_ff;
   assign tapv[0]     = dv_ff;
   assign acc_l[LAGS] = '0;

   for (genvar k = 0; k < LAGS; k++) begin : g_cell
      sac_cell #(.DW(DW), .AW(AW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .d_cur    (dev_ff),
         .tap_in   (tap[k]),
         .tap_vin  (tapv[k]),
         .tap_out  (tap[k+1]),
         .tap_vout (tapv[k+1]),
         .acc_in   (acc_l[k+1]),
         .acc_out  (acc_l[k])
      );
   end

   sac_div #(.AW(AW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (acc_l[0]),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo_w)
   );

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {2'b00, corr_ff, lag_ff};
   assign rsp_tuser  = den_ff == '0;
   assign rsp_tlast  = lag_ff == max_lag_ff;

   `SAC_ASSERT_NOW(a_rsp_in_emit, rsp_v_ff, state_ff == S_EMIT)
   `SAC_ASSERT_NOW(a_dev_in_calc, dv_ff, state_ff == S_CALC || state_ff == S_DRAIN)
   `SAC_ASSERT_NEXT(a_done_shows, div_done, rsp_v_ff)
endmodule
